/* design/periodic_time_histogram_model_defines.svh */
// assertion macros used by the histogram datapath
`ifndef PERIODIC_TIME_HISTOGRAM_MODEL_DEFINES_SVH
`define PERIODIC_TIME_HISTOGRAM_MODEL_DEFINES_SVH

// property checked on every clock edge outside reset
`define PHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition implies a consequence in the next cycle
`define PHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* design/phm_pkg.sv */
// types, constants and helpers of the periodic time histogram
package phm_pkg;

  localparam int NBINS     = 256;
  localparam int BIN_W     = $clog2(NBINS);
  localparam int NB_W      = 9;
  localparam int SUM_W     = 40;
  localparam int CNT_W     = 24;
  localparam int VAL_W     = 16;
  localparam int DIV_W     = 41;
  localparam int DVS_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [31:0]      TOTAL_MAX  = '1;
  localparam logic [VAL_W-1:0] CLAMP_LO   = 16'd66;
  localparam logic [VAL_W-1:0] CLAMP_HI   = 16'd65470;
  localparam logic [VAL_W-1:0] PRED_RESET = 16'd32768;
  localparam logic [16:0]      Q_ONE      = 17'd65536;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_EST     = 2'd1;
  localparam logic [1:0] REQ_COMMIT  = 2'd2;
  localparam logic [1:0] REQ_PREDICT = 2'd3;

  localparam logic [1:0] CFG_PERIOD     = 2'd0;
  localparam logic [1:0] CFG_NUM_BINS   = 2'd1;
  localparam logic [1:0] CFG_NUM_MODELS = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] time_req;
    logic [15:0] state_value;
  } item_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  bin_index;
    logic        bin_has_data;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FOLD, ST_FOLD_WAIT, ST_PROD, ST_SCALE_WAIT, ST_READ,
    ST_EXEC, ST_DIV_WAIT, ST_RESULT, ST_C_READ, ST_C_EXEC, ST_C_WAIT, ST_C_NEXT
  } state_e;

  typedef enum logic [1:0] {DIV_FOLD, DIV_SCALE, DIV_MEAN, DIV_DFLT} div_sel_e;
  typedef enum logic {ADDR_BIN, ADDR_SWEEP} addr_sel_e;
  typedef enum logic [1:0] {VAL_DIV, VAL_HI, VAL_PRED} val_sel_e;

  typedef struct packed {
    logic      load_item;
    logic      div_start;
    div_sel_e  div_sel;
    logic      load_prod;
    logic      load_bin;
    addr_sel_e addr_sel;
    logic      rd_en;
    logic      wr_clear;
    logic      wr_add;
    logic      wr_pred;
    logic      sweep_clr;
    logic      sweep_inc;
    logic      val_load;
    val_sel_e  val_sel;
    logic      has_load;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       cnt_zero;
    logic       nm_zero;
    logic       sweep_last;
    logic       sweep_full;
    logic       out_free;
    logic [1:0] req;
  } sts_t;

  function automatic logic [VAL_W-1:0] clamp_q(input logic [DIV_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v > DIV_W'(CLAMP_HI)) begin
      r = CLAMP_HI;
    end else if (v < DIV_W'(CLAMP_LO)) begin
      r = CLAMP_LO;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/phm_ram.sv */
// generic single write port, registered read ram
module phm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/phm_div.sv */
// restoring divider, one quotient bit per cycle
module phm_div import phm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [DVS_W-1:0] rem_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]     rem_q, rem_d, v_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W:0]       sh, diff;
  logic                 ge;

  assign sh    = {rem_q, quo_q[DIV_W-1]};
  assign diff  = sh - {1'b0, v_q};
  assign ge    = sh >= {1'b0, v_q};
  assign rem_d = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      v_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* design/phm_dp.sv */
// datapath: config registers, bin stores, divider and result register
`include "periodic_time_histogram_model_defines.svh"
module phm_dp import phm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  item_t       in_word_i,
  input  logic        out_stall_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  output result_t     out_word_o
);

  logic [31:0]      period_q;
  logic [NB_W-1:0]  num_bins_q;
  logic [7:0]       num_models_q;
  item_t            item_q;
  logic [DIV_W-1:0] prod_q;
  logic [BIN_W-1:0] bin_q, sweep_q, addr;
  logic [VAL_W-1:0] val_q;
  logic             has_q;
  logic             out_valid_q;
  result_t          out_word_q;
  logic [31:0]      total_q;

  logic [31:0]      p_used;
  logic [NB_W-1:0]  n_used;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor, div_rem;
  logic             div_busy, div_done;
  logic [SUM_W-1:0] sum_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic [VAL_W-1:0] pred_rd;
  logic             full, sc_we, pred_we;
  logic [SUM_W-1:0] sum_wd;
  logic [CNT_W-1:0] cnt_wd;
  logic [VAL_W-1:0] pred_wd;
  logic [2:0]       wr_vec;
  logic             est_or_pred, is_commit;

  // a zero period folds like one, bins in use stay within the built size
  assign p_used = (period_q == '0) ? 32'd1 : period_q;
  always_comb begin
    if (num_bins_q == '0) begin
      n_used = NB_W'(1);
    end else if (num_bins_q > NB_W'(NBINS)) begin
      n_used = NB_W'(NBINS);
    end else begin
      n_used = num_bins_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= 32'd86400;
      num_bins_q   <= NB_W'(256);
      num_models_q <= 8'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PERIOD:     period_q     <= cfg_data_i;
        CFG_NUM_BINS:   num_bins_q   <= cfg_data_i[NB_W-1:0];
        CFG_NUM_MODELS: num_models_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_FOLD: begin
        div_dividend = DIV_W'(item_q.time_req);
        div_divisor  = p_used;
      end
      DIV_SCALE: begin
        div_dividend = prod_q;
        div_divisor  = p_used;
      end
      DIV_MEAN: begin
        div_dividend = DIV_W'(sum_rd) + DIV_W'(cnt_rd >> 1);
        div_divisor  = DVS_W'(cnt_rd);
      end
      default: begin
        div_dividend = DIV_W'(Q_ONE) + DIV_W'(num_models_q >> 1);
        div_divisor  = DVS_W'(num_models_q);
      end
    endcase
  end

  phm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign addr    = (cmd_i.addr_sel == ADDR_SWEEP) ? sweep_q : bin_q;
  assign full    = (cnt_rd == COUNT_MAX);
  assign sc_we   = cmd_i.wr_clear || (cmd_i.wr_add && !full);
  assign pred_we = cmd_i.wr_clear || cmd_i.wr_pred;
  assign sum_wd  = cmd_i.wr_clear ? '0 : sum_rd + SUM_W'(item_q.state_value);
  assign cnt_wd  = cmd_i.wr_clear ? '0 : cnt_rd + CNT_W'(1);
  assign pred_wd = cmd_i.wr_clear ? PRED_RESET : div_quo[VAL_W-1:0];
  assign wr_vec  = {cmd_i.wr_clear, cmd_i.wr_add, cmd_i.wr_pred};

  phm_ram #(.WIDTH(SUM_W), .DEPTH(NBINS)) u_sum_ram (
    .clk_i (clk_i), .we_i (sc_we), .waddr_i (addr), .wdata_i (sum_wd),
    .re_i (cmd_i.rd_en), .raddr_i (addr), .rdata_o (sum_rd)
  );

  phm_ram #(.WIDTH(CNT_W), .DEPTH(NBINS)) u_cnt_ram (
    .clk_i (clk_i), .we_i (sc_we), .waddr_i (addr), .wdata_i (cnt_wd),
    .re_i (cmd_i.rd_en), .raddr_i (addr), .rdata_o (cnt_rd)
  );

  phm_ram #(.WIDTH(VAL_W), .DEPTH(NBINS)) u_pred_ram (
    .clk_i (clk_i), .we_i (pred_we), .waddr_i (addr), .wdata_i (pred_wd),
    .re_i (cmd_i.rd_en), .raddr_i (addr), .rdata_o (pred_rd)
  );

  assign est_or_pred = (item_q.req_type == REQ_EST) || (item_q.req_type == REQ_PREDICT);
  assign is_commit   = (item_q.req_type == REQ_COMMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (cmd_i.sweep_clr) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_inc) begin
        sweep_q <= sweep_q + BIN_W'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.wr_add && !full && total_q != TOTAL_MAX) begin
        total_q <= total_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
    end
    if (cmd_i.load_prod) begin
      prod_q <= DIV_W'(div_rem) * DIV_W'(n_used);
    end
    if (cmd_i.load_bin) begin
      bin_q <= div_quo[BIN_W-1:0];
    end
    if (cmd_i.has_load) begin
      has_q <= (item_q.req_type == REQ_ADD) || (cnt_rd != '0);
    end
    if (cmd_i.val_load) begin
      case (cmd_i.val_sel)
        VAL_DIV:  val_q <= clamp_q(div_quo);
        VAL_PRED: val_q <= clamp_q(DIV_W'(pred_rd));
        default:  val_q <= CLAMP_HI;
      endcase
    end
    if (cmd_i.res_load) begin
      out_word_q.value        <= est_or_pred ? val_q : '0;
      out_word_q.bin_index    <= is_commit ? '0 : 8'(bin_q);
      out_word_q.bin_has_data <= is_commit ? 1'b0 : has_q;
    end
  end

  assign sts_o.div_done   = div_done;
  assign sts_o.cnt_zero   = (cnt_rd == '0);
  assign sts_o.nm_zero    = (num_models_q == '0);
  assign sts_o.sweep_last = ({1'b0, sweep_q} == NB_W'(n_used - NB_W'(1)));
  assign sts_o.sweep_full = (sweep_q == BIN_W'(NBINS - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.req        = item_q.req_type;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `PHM_ASSERT(a_wr_excl, $onehot0(wr_vec), "ram write commands overlap")
  `PHM_ASSERT(a_div_idle, cmd_i.div_start |-> !div_busy, "divide started while busy")
  `PHM_ASSERT_NEXT(a_div_run, cmd_i.div_start, div_busy, "divider did not start")
  `PHM_ASSERT(a_res_free, cmd_i.res_load |-> (!out_valid_q || !out_stall_i), "result lost")

endmodule

/* design/phm_ctrl.sv */
// controller state machine sequencing the histogram datapath
module phm_ctrl import phm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:      if (sts_i.sweep_full) state_d = ST_IDLE;
      ST_IDLE:       if (in_valid_i) state_d = ST_FOLD;
      ST_FOLD:       state_d = (sts_i.req == REQ_COMMIT) ? ST_C_READ : ST_FOLD_WAIT;
      ST_FOLD_WAIT:  if (sts_i.div_done) state_d = ST_PROD;
      ST_PROD:       state_d = ST_SCALE_WAIT;
      ST_SCALE_WAIT: if (sts_i.div_done) state_d = ST_READ;
      ST_READ:       state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.req == REQ_EST && (!sts_i.cnt_zero || !sts_i.nm_zero)) begin
          state_d = ST_DIV_WAIT;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_DIV_WAIT:   if (sts_i.div_done) state_d = ST_RESULT;
      ST_RESULT:     if (sts_i.out_free) state_d = ST_IDLE;
      ST_C_READ:     state_d = ST_C_EXEC;
      ST_C_EXEC:     state_d = sts_i.cnt_zero ? ST_C_NEXT : ST_C_WAIT;
      ST_C_WAIT:     if (sts_i.div_done) state_d = ST_C_NEXT;
      ST_C_NEXT:     state_d = sts_i.sweep_last ? ST_RESULT : ST_C_READ;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.div_sel  = DIV_FOLD;
    cmd_o.addr_sel = ADDR_BIN;
    cmd_o.val_sel  = VAL_DIV;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.addr_sel  = ADDR_SWEEP;
        cmd_o.wr_clear  = 1'b1;
        cmd_o.sweep_inc = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_FOLD: begin
        if (sts_i.req == REQ_COMMIT) begin
          cmd_o.sweep_clr = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_FOLD_WAIT: cmd_o.load_prod = sts_i.div_done;
      ST_PROD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SCALE;
      end
      ST_SCALE_WAIT: cmd_o.load_bin = sts_i.div_done;
      ST_READ:       cmd_o.rd_en = 1'b1;
      ST_EXEC: begin
        cmd_o.has_load = 1'b1;
        case (sts_i.req)
          REQ_ADD: cmd_o.wr_add = 1'b1;
          REQ_EST: begin
            if (!sts_i.cnt_zero) begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_MEAN;
            end else if (sts_i.nm_zero) begin
              cmd_o.val_load = 1'b1;
              cmd_o.val_sel  = VAL_HI;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_DFLT;
            end
          end
          REQ_PREDICT: begin
            cmd_o.val_load = 1'b1;
            cmd_o.val_sel  = VAL_PRED;
          end
          default: ;
        endcase
      end
      ST_DIV_WAIT: cmd_o.val_load = sts_i.div_done;
      ST_RESULT:   cmd_o.res_load = sts_i.out_free;
      ST_C_READ: begin
        cmd_o.addr_sel = ADDR_SWEEP;
        cmd_o.rd_en    = 1'b1;
      end
      ST_C_EXEC: begin
        cmd_o.addr_sel  = ADDR_SWEEP;
        cmd_o.div_start = !sts_i.cnt_zero;
        cmd_o.div_sel   = DIV_MEAN;
      end
      ST_C_WAIT: begin
        cmd_o.addr_sel = ADDR_SWEEP;
        cmd_o.div_sel  = DIV_MEAN;
        cmd_o.wr_pred  = sts_i.div_done;
      end
      ST_C_NEXT: cmd_o.sweep_inc = !sts_i.sweep_last;
      default: ;
    endcase
  end

endmodule

/* design/periodic_time_histogram_model.sv */
// Periodic time histogram, top level. Each request word carries a request type, a
// timestamp and a Q0.16 state value, and produces exactly one result word. The time is
// folded into the configured period and scaled onto the bins in use with exact
// arithmetic; add accumulates into the bin's sum and saturating count, estimate returns
// the clamped bin mean (or 1/num_models for an empty bin, 65470 if num_models is zero),
// commit copies the mean of every non-empty bin in use into the prediction store and
// predict reads that store. Estimate and predict values are clamped to [66, 65470];
// add and commit return a zero value. One word is worked on at a time; every step that
// divides goes through one shared restoring divider that yields one quotient bit per
// cycle. A commit sweeps the bins in use and divides only for the filled ones, and each
// result passes through the output register. After reset a clearing pass over all 256
// bins initializes the bin stores, while input words stall; configuration writes are
// always taken.
module periodic_time_histogram_model import phm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  item_t       in_word_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_word_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // registers are plain flops, a write never has to wait
  assign cfg_ready_o = 1'b1;

  // sequencer: clearing pass, fold, scale, store access, mean and commit sweep
  phm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // bin stores, divider, config and the output register that decouples the result side
  phm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
